@@ sv/bblur_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types and constants of the 3x3 box blur with replicated borders.
// ----------------------------------------------------------------------------
package bblur_pkg;

  // Field and register widths
  localparam int unsigned DEN_W  = 16;   // density / blurred pixel width
  localparam int unsigned CFG_W  = 11;   // configuration register width
  localparam int unsigned ROW_W  = 10;   // row counter width
  localparam int unsigned CSUM_W = 18;   // sum of one three-pixel column
  localparam int unsigned WSUM_W = 20;   // sum of the whole 3x3 window

  // Defaults and limits
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned HEIGHT_LIMIT  = 1024;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd256;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Divide by nine: floor(s * RECIP / 2^SHIFT) is exact for any 20-bit s
  localparam int unsigned DIV9_SHIFT = 23;
  localparam logic [WSUM_W-1:0] DIV9_RECIP = 20'd932068;

  // Result queue
  localparam int unsigned RQ_DEPTH = 16;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

  // One queued result before the divide
  typedef struct packed {
    logic              last;
    logic [WSUM_W-1:0] sum;
  } rq_entry_t;

endpackage

@@ sv/box_blur_3x3_clamped_edges_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_clamped_edges_unit
// 3x3 mean filter over a raster density stream, edges replicated.
// ----------------------------------------------------------------------------
// The unit takes one density pixel per cycle while s_axis_tready is high and
// returns each pixel's 3x3 mean (sum of nine / 9, truncated) one row and one
// column behind the input. The two previous rows live in a single line memory
// of MAX_WIDTH x 32 bits (one read port, one write port, registered read);
// back-to-back accesses to the same column, which only a one-pixel-wide frame
// causes, are forwarded. A result goes through stages B and C, the result
// queue and the output register; the second result of a row end follows it.
// Every row of W pixels after the first yields W results and every flush
// item one, so with a sink that is always ready the input never stalls; a
// 16-entry result queue absorbs the cycles that emit two results and any sink
// stalls, and the input stalls only while fewer than six entries are free.
// After the last pixel of a frame, W flush items (tuser = 1) return the bottom
// row; frame_end travels on tlast. Writing a register restarts the frame.
module box_blur_3x3_clamped_edges_unit #(
  parameter int unsigned MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bblur_pkg::CFG_W-1:0]      cfg_wdata_i,
  // Input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bblur_pkg::DEN_W-1:0]      s_axis_tdata,  // [15:0] density
  input  logic                             s_axis_tuser,  // [0] mode (1 = flush)
  // Output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bblur_pkg::DEN_W-1:0]      m_axis_tdata,  // [15:0] blurred
  output logic                             m_axis_tlast   // frame_end
);
  import bblur_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned MW = 2 * DEN_W;

  // --------------------------------------------------------------------------
  // Configuration and position state
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [AW-1:0]    col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]    flush_q, flush_d;
  logic [CW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;

  // Clamp the frame size to its legal range
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      eff_h = CFG_W'(1);
    end else if (32'(frame_height_q) > HEIGHT_LIMIT) begin
      eff_h = CFG_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = frame_height_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: accept, decide position, issue line memory read
  // --------------------------------------------------------------------------
  logic             in_acc;
  logic             a_flush, a_flush_ok, a_restart, a_valid;
  logic [AW-1:0]    a_x, a_xr;
  logic [ROW_W-1:0] a_y, a_yr;
  logic             a_x0, a_xlast, a_take, a_topsel;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    a_flush    = s_axis_tuser;
    a_flush_ok = (flush_q != '0) && (flush_q <= eff_w);
    a_restart  = (flush_q != '0);
    a_xr       = a_restart ? '0 : col_q;
    a_yr       = a_restart ? '0 : row_q;
    a_y        = (CFG_W'(a_yr) >= eff_h) ? '0 : a_yr;
    if (a_flush) begin
      a_x      = AW'(eff_w - flush_q);
      a_take   = 1'b1;
      a_topsel = (eff_h == CFG_W'(1));
    end else begin
      a_x      = (CW'(a_xr) >= eff_w) ? '0 : a_xr;
      a_take   = (a_y != '0);
      a_topsel = (a_y <= ROW_W'(1));
    end
    a_x0    = (a_x == '0);
    a_xlast = (CW'(a_x) == eff_w - CW'(1));
    a_valid = in_acc && (!a_flush || a_flush_ok);
  end

  // Next position counters
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (in_acc) begin
      if (a_flush) begin
        if (a_flush_ok) begin
          flush_d = flush_q - CW'(1);
        end
      end else begin
        flush_d = '0;
        if (a_xlast) begin
          col_d = '0;
          if (CFG_W'(a_y) == eff_h - CFG_W'(1)) begin
            row_d   = '0;
            flush_d = eff_w;
          end else begin
            row_d = a_y + ROW_W'(1);
          end
        end else begin
          col_d = a_x + AW'(1);
          row_d = a_y;
        end
      end
    end
  end

  // Hold registers and counters; a register write restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      col_q          <= '0;
      row_q          <= '0;
      flush_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      flush_q <= flush_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: [31:16] row above, [15:0] row two above
  // --------------------------------------------------------------------------
  logic [MW-1:0]    line_mem [MAX_WIDTH];
  logic [MW-1:0]    rd_data_q;
  logic             b_valid_q, b_pix_q, b_x0_q, b_xlast_q, b_take_q, b_topsel_q;
  logic [AW-1:0]    b_x_q;
  logic [DEN_W-1:0] b_den_q;
  logic             fwd_q;
  logic [MW-1:0]    fwd_data_q;
  logic [DEN_W-1:0] b_top, b_mid, b_bot;
  logic [MW-1:0]    b_line;
  logic             b_wr;

  assign b_wr = b_valid_q && b_pix_q;

  // Read every cycle at the stage A column, write back from stage B
  always_ff @(posedge clk_i) begin
    rd_data_q <= line_mem[a_x];
    if (b_wr) begin
      line_mem[b_x_q] <= {b_bot, b_mid};
    end
  end

  // Forward a write to the same column that stage A reads this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= a_valid && b_wr && (b_x_q == a_x);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= {b_bot, b_mid};
  end

  // Stage A to B control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid;
    end
  end

  // Stage A to B payload
  always_ff @(posedge clk_i) begin
    if (a_valid) begin
      b_pix_q    <= !a_flush;
      b_x_q      <= a_x;
      b_x0_q     <= a_x0;
      b_xlast_q  <= a_xlast;
      b_take_q   <= a_take;
      b_topsel_q <= a_topsel;
      b_den_q    <= s_axis_tdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: build the column, shift the window
  // --------------------------------------------------------------------------
  logic [CSUM_W-1:0] b_csum;
  logic [CSUM_W-1:0] win_q [3];
  logic              b_shift;

  always_comb begin
    b_line  = fwd_q ? fwd_data_q : rd_data_q;
    b_mid   = b_line[MW-1:DEN_W];
    b_top   = b_topsel_q ? b_mid : b_line[DEN_W-1:0];
    b_bot   = b_pix_q ? b_den_q : b_mid;
    b_csum  = CSUM_W'(b_top) + CSUM_W'(b_mid) + CSUM_W'(b_bot);
    b_shift = b_valid_q && b_take_q;
  end

  // Load all three columns at the left edge, else shift left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (b_shift) begin
      if (b_x0_q) begin
        win_q[0] <= b_csum;
        win_q[1] <= b_csum;
      end else begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
      end
      win_q[2] <= b_csum;
    end
  end

  // Stage B to C
  logic c_valid_q, c_emit_a_q, c_emit_b_q, c_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q  <= 1'b0;
      c_emit_a_q <= 1'b0;
      c_emit_b_q <= 1'b0;
      c_last_q   <= 1'b0;
    end else begin
      c_valid_q  <= b_shift;
      c_emit_a_q <= b_shift && !b_x0_q;
      c_emit_b_q <= b_shift && b_xlast_q;
      c_last_q   <= b_shift && b_xlast_q && !b_pix_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: window sums into the result queue
  // --------------------------------------------------------------------------
  logic [WSUM_W-1:0] c_sum_a, c_sum_b;
  logic              push_a, push_b;

  assign c_sum_a = WSUM_W'(win_q[0]) + WSUM_W'(win_q[1]) + WSUM_W'(win_q[2]);
  assign c_sum_b = WSUM_W'(win_q[1]) + (WSUM_W'(win_q[2]) << 1);
  assign push_a  = c_valid_q && c_emit_a_q;
  assign push_b  = c_valid_q && c_emit_b_q;

  rq_entry_t         rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0]  rq_wr_q, rq_rd_q;
  logic [RQ_CW-1:0]  rq_cnt_q, rq_cnt_d;
  logic              rq_pop;
  rq_entry_t         rq_head;

  // Queue storage: up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (push_a) begin
      rq_mem[rq_wr_q] <= '{last: 1'b0, sum: c_sum_a};
    end
    if (push_b) begin
      rq_mem[rq_wr_q + RQ_AW'(push_a)] <= '{last: c_last_q, sum: c_sum_b};
    end
  end

  assign rq_head  = rq_mem[rq_rd_q];
  assign rq_pop   = (rq_cnt_q != '0) && (!m_axis_tvalid || m_axis_tready);
  assign rq_cnt_d = rq_cnt_q + RQ_CW'(push_a) + RQ_CW'(push_b) - RQ_CW'(rq_pop);

  // Reserve room for everything in flight plus the next item
  assign s_axis_tready = (rq_cnt_q <= RQ_CW'(RQ_DEPTH - 6));

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_wr_q  <= rq_wr_q + RQ_AW'(push_a) + RQ_AW'(push_b);
      rq_rd_q  <= rq_rd_q + RQ_AW'(rq_pop);
      rq_cnt_q <= rq_cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: divide by nine on the way out
  // --------------------------------------------------------------------------
  logic [2*WSUM_W-1:0] div_prod;
  logic                out_valid_q;
  logic [DEN_W-1:0]    out_data_q;
  logic                out_last_q;

  assign div_prod = (2*WSUM_W)'(rq_head.sum) * (2*WSUM_W)'(DIV9_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rq_pop) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_pop) begin
      out_data_q <= div_prod[DIV9_SHIFT +: DEN_W];
      out_last_q <= rq_head.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_rq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_fwd_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && fwd_q) |-> (eff_w == CW'(1)))
    else $error("line memory forward outside a one-column frame");

  a_last_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && c_last_q) |-> c_emit_b_q)
    else $error("frame end on a result that is not a row end");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_a || push_b) |=> (rq_cnt_q != '0))
    else $error("queue empty after a push");

endmodule
